### rtl/core/tcpm_pkg.sv
// ----------------------------------------------------------------------------
// tcpm_pkg: shared types and constants of the two channel phase meter
// counter width, phase codes, status codes, register indexes and the
// measurement record handed from the front end to the back end
// ----------------------------------------------------------------------------
`default_nettype none

package tcpm_pkg;

  // tick counter width and its saturation value
  localparam int CNT_W = 24;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // divider sizing: dividend is 360 * delay
  localparam int MUL_W = 9;
  localparam logic [MUL_W-1:0] DEG_FULL = MUL_W'(360);
  localparam int DVD_W = CNT_W + MUL_W;
  localparam int ITER_W = $clog2(DVD_W);

  // gain and scaling
  localparam int GAIN_W = 11;
  localparam int FRAC_W = 10;
  localparam int QC_W = 21;
  localparam logic [QC_W-1:0] Q_CLAMP = QC_W'(1) << 20;
  localparam int PROD_W = QC_W + GAIN_W;
  localparam int DEG_W = 10;
  localparam logic [DEG_W-1:0] DEG_MAX = {DEG_W{1'b1}};

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS = 2'd2;

  localparam logic [7:0] TRIGGER_RESET = 8'd255;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1055);

  // result status codes
  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO_PERIOD = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

  // queue depth
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = 1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ARMED  = 3'd1,
    PH_PERIOD = 3'd2,
    PH_DELAY  = 3'd3,
    PH_HALT   = 3'd4
  } meas_phase_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_SCALE,
    B_SAT,
    B_HOLD
  } back_state_t;

  // configuration as seen by both ends
  typedef struct packed {
    logic [7:0]        trigger_level;
    logic [GAIN_W-1:0] gain_q10;
    logic              continuous;
  } cfg_t;

  // one finished measurement
  typedef struct packed {
    logic [CNT_W-1:0] delay;
    logic [CNT_W-1:0] period;
    logic             overflow;
  } job_t;

endpackage

`default_nettype wire

### rtl/core/tcpm_front.sv
// ----------------------------------------------------------------------------
// tcpm_front: sample front end
// classifies each sample word against the trigger level, runs the
// measurement phases and pushes a finished measurement into the queue
// ----------------------------------------------------------------------------
`default_nettype none

module tcpm_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tcpm_pkg::cfg_t       cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           ref_sample,
  input  wire logic [7:0]           test_sample,
  input  wire logic                 q_full,
  output logic                      push,
  output tcpm_pkg::job_t            job
);

  tcpm_pkg::meas_phase_t phase, phase_next;
  logic [tcpm_pkg::CNT_W-1:0] tick_count, tick_count_next;
  logic [tcpm_pkg::CNT_W-1:0] period_ticks, period_ticks_next;
  logic overflow_seen, overflow_seen_next;

  logic accept;
  logic ref_high, test_high;
  logic cnt_sat;
  logic [tcpm_pkg::CNT_W-1:0] tick_inc;
  logic ovf_inc;
  logic emit;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  // level classification
  assign ref_high = ref_sample >= cfg.trigger_level;
  assign test_high = test_sample >= cfg.trigger_level;

  // saturating tick count
  assign cnt_sat = tick_count == tcpm_pkg::CNT_MAX;
  assign tick_inc = cnt_sat ? tcpm_pkg::CNT_MAX : tick_count + 1'b1;
  assign ovf_inc = overflow_seen | cnt_sat;

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        tcpm_pkg::PH_IDLE: begin
          if (ref_high) phase_next = tcpm_pkg::PH_ARMED;
        end
        tcpm_pkg::PH_ARMED: begin
          if (!ref_high) phase_next = tcpm_pkg::PH_PERIOD;
        end
        tcpm_pkg::PH_PERIOD: begin
          if (ref_high) begin
            if (test_high) begin
              phase_next = cfg.continuous ? tcpm_pkg::PH_IDLE : tcpm_pkg::PH_HALT;
            end else begin
              phase_next = tcpm_pkg::PH_DELAY;
            end
          end
        end
        tcpm_pkg::PH_DELAY: begin
          if (test_high) begin
            phase_next = cfg.continuous ? tcpm_pkg::PH_IDLE : tcpm_pkg::PH_HALT;
          end
        end
        default: phase_next = tcpm_pkg::PH_HALT;
      endcase
    end
  end

  // counters and result word
  always_comb begin
    tick_count_next = tick_count;
    period_ticks_next = period_ticks;
    overflow_seen_next = overflow_seen;
    emit = 1'b0;
    job.delay = tick_inc;
    job.period = period_ticks;
    job.overflow = ovf_inc;
    if (accept) begin
      unique case (phase)
        tcpm_pkg::PH_IDLE: begin
          if (ref_high) begin
            tick_count_next = '0;
            overflow_seen_next = 1'b0;
          end
        end
        tcpm_pkg::PH_ARMED: begin
          tick_count_next = tick_inc;
          overflow_seen_next = ovf_inc;
        end
        tcpm_pkg::PH_PERIOD: begin
          tick_count_next = tick_inc;
          overflow_seen_next = ovf_inc;
          if (ref_high) begin
            period_ticks_next = tick_inc;
            tick_count_next = '0;
            // delay of zero when channel 1 is already high
            job.delay = '0;
            job.period = tick_inc;
            emit = test_high;
          end
        end
        tcpm_pkg::PH_DELAY: begin
          tick_count_next = tick_inc;
          overflow_seen_next = ovf_inc;
          emit = test_high;
        end
        default: begin
        end
      endcase
    end
  end

  assign push = emit;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tcpm_pkg::PH_IDLE;
      tick_count <= '0;
      period_ticks <= '0;
      overflow_seen <= 1'b0;
    end else begin
      phase <= phase_next;
      tick_count <= tick_count_next;
      period_ticks <= period_ticks_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tcpm_queue.sv
// ----------------------------------------------------------------------------
// tcpm_queue: two entry measurement queue
// decouples the sample front end from the divider back end
// ----------------------------------------------------------------------------
`default_nettype none

module tcpm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tcpm_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output tcpm_pkg::job_t      head
);

  tcpm_pkg::job_t entries [tcpm_pkg::Q_DEPTH];
  logic [tcpm_pkg::Q_AW-1:0] wr_ptr, rd_ptr;
  logic [tcpm_pkg::Q_AW:0] fill;

  assign full = fill == (tcpm_pkg::Q_AW+1)'(tcpm_pkg::Q_DEPTH);
  assign not_empty = fill != '0;
  assign head = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tcpm_back.sv
// ----------------------------------------------------------------------------
// tcpm_back: phase computation back end
// scales the delay by 360, divides by the period one quotient bit a cycle,
// applies the Q10 gain with saturation and holds the result word
// ----------------------------------------------------------------------------
`default_nettype none

module tcpm_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [tcpm_pkg::GAIN_W-1:0] gain_q10,
  input  wire logic                        q_not_empty,
  input  wire tcpm_pkg::job_t              q_head,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [tcpm_pkg::DEG_W-1:0]       out_phase,
  output logic [tcpm_pkg::ST_W-1:0]        out_status
);

  tcpm_pkg::back_state_t state, state_next;
  tcpm_pkg::job_t job_r;
  logic [tcpm_pkg::DVD_W-1:0] dvd;
  logic [tcpm_pkg::CNT_W:0] rem;
  logic [tcpm_pkg::ITER_W-1:0] iter;
  logic [tcpm_pkg::PROD_W-1:0] prod;
  logic [tcpm_pkg::DEG_W-1:0] deg;
  logic [tcpm_pkg::ST_W-1:0] status_r;

  logic out_free;
  logic load_out;
  logic [tcpm_pkg::CNT_W:0] rem_shift;
  logic rem_ge;
  logic [tcpm_pkg::QC_W-1:0] q_clamped;
  logic [tcpm_pkg::PROD_W-tcpm_pkg::FRAC_W-1:0] prod_hi;

  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcpm_pkg::B_IDLE: begin
        if (q_not_empty) begin
          if (q_head.period == '0 || q_head.overflow) state_next = tcpm_pkg::B_HOLD;
          else state_next = tcpm_pkg::B_MUL;
        end
      end
      tcpm_pkg::B_MUL:   state_next = tcpm_pkg::B_DIV;
      tcpm_pkg::B_DIV: begin
        if (iter == '0) state_next = tcpm_pkg::B_SCALE;
      end
      tcpm_pkg::B_SCALE: state_next = tcpm_pkg::B_SAT;
      tcpm_pkg::B_SAT:   state_next = tcpm_pkg::B_HOLD;
      tcpm_pkg::B_HOLD: begin
        if (out_free) state_next = tcpm_pkg::B_IDLE;
      end
      default: state_next = tcpm_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop = 1'b0;
    load_out = 1'b0;
    unique case (state)
      tcpm_pkg::B_IDLE: pop = q_not_empty;
      tcpm_pkg::B_HOLD: load_out = out_free;
      default: begin
      end
    endcase
  end

  // restoring divide step
  assign rem_shift = {rem[tcpm_pkg::CNT_W-1:0], dvd[tcpm_pkg::DVD_W-1]};
  assign rem_ge = rem_shift >= {1'b0, job_r.period};

  // quotients of 2^20 and above saturate for any non-zero gain
  assign q_clamped = (dvd >= tcpm_pkg::DVD_W'(tcpm_pkg::Q_CLAMP)) ?
                     tcpm_pkg::Q_CLAMP : dvd[tcpm_pkg::QC_W-1:0];
  assign prod_hi = prod[tcpm_pkg::PROD_W-1:tcpm_pkg::FRAC_W];

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      tcpm_pkg::B_IDLE: begin
        job_r <= q_head;
        deg <= '0;
        if (q_head.period == '0) status_r <= tcpm_pkg::ST_ZERO_PERIOD;
        else if (q_head.overflow) status_r <= tcpm_pkg::ST_OVERFLOW;
        else status_r <= tcpm_pkg::ST_OK;
      end
      tcpm_pkg::B_MUL: begin
        dvd <= tcpm_pkg::DVD_W'(job_r.delay) * tcpm_pkg::DVD_W'(tcpm_pkg::DEG_FULL);
        rem <= '0;
        iter <= tcpm_pkg::ITER_W'(tcpm_pkg::DVD_W - 1);
      end
      tcpm_pkg::B_DIV: begin
        rem <= rem_ge ? rem_shift - {1'b0, job_r.period} : rem_shift;
        dvd <= {dvd[tcpm_pkg::DVD_W-2:0], rem_ge};
        iter <= iter - 1'b1;
      end
      tcpm_pkg::B_SCALE: begin
        prod <= tcpm_pkg::PROD_W'(q_clamped) * tcpm_pkg::PROD_W'(gain_q10);
      end
      tcpm_pkg::B_SAT: begin
        deg <= (prod_hi > (tcpm_pkg::PROD_W-tcpm_pkg::FRAC_W)'(tcpm_pkg::DEG_MAX)) ?
               tcpm_pkg::DEG_MAX : prod_hi[tcpm_pkg::DEG_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_phase <= deg;
      out_status <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcpm_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/two_channel_phase_meter.sv
// ----------------------------------------------------------------------------
// two_channel_phase_meter: zero crossing phase meter for two channels
// samples in, one phase word out per completed measurement
// ----------------------------------------------------------------------------
// One sample word (both channels) is taken per clock cycle. A measurement
// arms on the first rise of channel 0, times one period of channel 0 and
// then the delay to channel 1 reaching the trigger level. The finished
// measurement goes into a two entry queue; the back end turns it into
// degrees with a multiply, a 33 step bit-serial divider, a gain multiply,
// saturation and an output load.
// The sample input stalls only while the queue holds two measurements.
// Zero period and counter overflow give status codes with a phase of zero.
// Without continuous mode the block halts after the first result until
// reset.
`default_nettype none

module two_channel_phase_meter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [tcpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcpm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [15:0]                    s_tdata,  // ref_sample, test_sample
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [15:0]                         m_tdata,  // phase_degrees, zero fill
  output logic [1:0]                          m_tuser   // status
);

  tcpm_pkg::cfg_t cfg;
  tcpm_pkg::job_t push_job, head_job;
  logic push, pop, q_full, q_not_empty;
  logic [tcpm_pkg::DEG_W-1:0] phase_deg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_level <= tcpm_pkg::TRIGGER_RESET;
      cfg.gain_q10 <= tcpm_pkg::GAIN_RESET;
      cfg.continuous <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcpm_pkg::REG_TRIGGER:    cfg.trigger_level <= cfg_data[7:0];
        tcpm_pkg::REG_GAIN:       cfg.gain_q10 <= cfg_data;
        tcpm_pkg::REG_CONTINUOUS: cfg.continuous <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  tcpm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .ref_sample  (s_tdata[7:0]),
    .test_sample (s_tdata[15:8]),
    .q_full      (q_full),
    .push        (push),
    .job         (push_job)
  );

  tcpm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head_job)
  );

  tcpm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .gain_q10    (cfg.gain_q10),
    .q_not_empty (q_not_empty),
    .q_head      (head_job),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_phase   (phase_deg),
    .out_status  (m_tuser)
  );

  assign m_tdata = {6'd0, phase_deg};

endmodule

`default_nettype wire

### rtl/core/tcpm_checker.sv
// ----------------------------------------------------------------------------
// tcpm_checker: port level checks of the phase meter
// watches the result channel over time and is bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tcpm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // error status always carries a zero phase
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != tcpm_pkg::ST_OK |-> m_tdata[9:0] == 10'd0)
    else $error("error status with non-zero phase");

  // only defined status codes, zero fill above the phase
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 2'd3) && (m_tdata[15:10] == 6'd0))
    else $error("bad status code or fill bits");

  // reset empties the result register
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind two_channel_phase_meter tcpm_checker u_tcpm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

### dv/tb_two_channel_phase_meter.sv
// ----------------------------------------------------------------------------
// tb_two_channel_phase_meter: self-checking bench for the phase meter
// sample words go in on the stream input, with random gaps on both sides. An
// in-bench model of the front end predicts the phase word each measurement
// should give, and the words on the stream output are compared in order.
// The run covers a short directed part and then random measurement sequences
// under several trigger, gain and mode settings. It ends in halt mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_channel_phase_meter;
  import tcpm_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [DEG_W-1:0] deg;
    logic [ST_W-1:0]  status;
  } phase_word_t;

  // bench-driven inputs, known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic [15:0]           s_tdata = '0;
  logic                  m_tready = 1'b0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [15:0]           m_tdata;
  logic [1:0]            m_tuser;

  // register copy used by the stimulus and the prediction
  logic [7:0]            trig_level = TRIGGER_RESET;
  logic [GAIN_W-1:0]     gain = GAIN_RESET;
  logic                  cont_mode = 1'b0;

  // front end state of the prediction
  meas_phase_t           meter_phase = PH_IDLE;
  logic [CNT_W-1:0]      tick_run = '0;
  logic [CNT_W-1:0]      period_run = '0;
  logic                  count_sat = 1'b0;

  logic [15:0]           sample_q[$];
  phase_word_t           phase_expect_q[$];
  phase_word_t           want;

  int                    errors = 0;
  int                    words_in = 0;
  int                    phase_words = 0;
  int                    gen_items = 0;
  int                    gen_meas = 0;
  int                    settings_used = 0;
  int                    sample_gap = 0;
  int                    sink_gap = 0;
  int                    stall_cycles = 0;
  bit                    idle_on = 1'b1;

  two_channel_phase_meter DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // ref_sample, test_sample
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // phase_degrees, zero fill
    .m_tuser   (m_tuser)    // status
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // saturating tick counter
  task automatic count_tick();
    if (tick_run == CNT_MAX) begin
      count_sat = 1'b1;
    end else begin
      tick_run = tick_run + 1'b1;
    end
  endtask

  // advance the measurement by one sample word, queue a phase word if one ends
  task automatic track_sample(input logic [15:0] word);
    logic              ch0_hi;
    logic              ch1_hi;
    logic              emit;
    longint unsigned   quot;
    longint unsigned   scaled;
    phase_word_t       res;
    ch0_hi = word[7:0] >= trig_level;
    ch1_hi = word[15:8] >= trig_level;
    emit = 1'b0;
    case (meter_phase)
      PH_IDLE: begin
        if (ch0_hi) begin
          tick_run = '0;
          count_sat = 1'b0;
          meter_phase = PH_ARMED;
        end
      end
      PH_ARMED: begin
        count_tick();
        if (!ch0_hi) meter_phase = PH_PERIOD;
      end
      PH_PERIOD: begin
        count_tick();
        // rise of channel 0 closes the period; channel 1 may already be high
        if (ch0_hi) begin
          period_run = tick_run;
          tick_run = '0;
          meter_phase = PH_DELAY;
          emit = ch1_hi;
        end
      end
      PH_DELAY: begin
        count_tick();
        emit = ch1_hi;
      end
      default: begin
        meter_phase = PH_HALT;
      end
    endcase
    if (emit) begin
      res = '0;
      if (period_run == '0) begin
        res.status = ST_ZERO_PERIOD;
      end else if (count_sat) begin
        res.status = ST_OVERFLOW;
      end else begin
        quot = (64'd360 * tick_run) / period_run;
        scaled = (quot * gain) >> FRAC_W;
        res.deg = (scaled > DEG_MAX) ? DEG_MAX : scaled[DEG_W-1:0];
        res.status = ST_OK;
      end
      phase_expect_q.push_back(res);
      meter_phase = cont_mode ? PH_IDLE : PH_HALT;
    end
  endtask

  // sample word source with random gaps between words
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_sample(s_tdata);
        words_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (sample_gap > 0) begin
          sample_gap--;
          s_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
          sample_gap = $urandom_range(0, 8);
          s_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          s_tdata <= sample_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // phase word sink: check against the oldest prediction, stall at random
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (phase_expect_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected phase word: deg %0d status %0d",
                     m_tdata[DEG_W-1:0], m_tuser);
        end else begin
          want = phase_expect_q.pop_front();
          phase_words++;
          if (m_tdata != 16'(want.deg) || m_tuser != want.status) begin
            errors++;
            if (errors <= 10)
              $display("phase word %0d: expected deg %0d status %0d, got tdata 0x%04h status %0d",
                       phase_words, want.deg, want.status, m_tdata, m_tuser);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        sink_gap = $urandom_range(0, 8);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d phase words outstanding",
                 stall_cycles, phase_expect_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // wait until every word is in and every phase word is out, then let it drain
  task automatic settle();
    while (sample_q.size() != 0 || s_tvalid || phase_expect_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  task automatic apply_settings(input logic [7:0] trig, input logic [GAIN_W-1:0] g,
                                input logic cont);
    settle();
    write_reg(REG_TRIGGER, CFG_DATA_W'(trig));
    write_reg(REG_GAIN, g);
    write_reg(REG_CONTINUOUS, CFG_DATA_W'(cont));
    @(posedge clk);
    cfg_we <= 1'b0;
    trig_level = trig;
    gain = g;
    cont_mode = cont;
    settings_used++;
  endtask

  task automatic push_sample(input logic [7:0] ch0, input logic [7:0] ch1);
    sample_q.push_back({ch1, ch0});
    gen_items++;
  endtask

  // sample values on either side of the trigger level, edges favoured
  function automatic logic [7:0] above();
    case ($urandom_range(0, 5))
      0:       return trig_level;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255, trig_level));
    endcase
  endfunction

  function automatic logic [7:0] below();
    case ($urandom_range(0, 5))
      0:       return trig_level - 8'd1;
      1:       return 8'h00;
      default: return 8'($urandom_range(trig_level - 1, 0));
    endcase
  endfunction

  function automatic logic [7:0] any_sample();
    return 8'($urandom_range(0, 255));
  endfunction

  // one well formed measurement: arm, hold high, low run, rise, then delay
  task automatic push_measurement(input int hold, input int low_run, input int lag);
    repeat ($urandom_range(0, 2)) push_sample(below(), any_sample());
    push_sample(above(), any_sample());
    repeat (hold) push_sample(above(), any_sample());
    repeat (low_run) push_sample(below(), any_sample());
    push_sample(above(), (lag == 0) ? above() : below());
    if (lag > 0) begin
      repeat (lag - 1) push_sample(any_sample(), below());
      push_sample(any_sample(), above());
    end
    gen_meas++;
  endtask

  // one setting, then mostly measurements with some noise mixed in
  task automatic run_phase(input int unsigned trig, input int unsigned g,
                           input bit cont, input int budget, input bit idle);
    int start;
    int hold;
    int low_run;
    int per;
    int lag;
    apply_settings(8'(trig), GAIN_W'(g), cont);
    idle_on = idle;
    start = gen_items;
    while (gen_items - start < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        hold = $urandom_range(0, 5);
        low_run = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
        per = hold + low_run + 1;
        lag = ($urandom_range(0, 4) == 0) ? $urandom_range(per, 3 * per)
                                          : $urandom_range(0, per);
        push_measurement(hold, low_run, lag);
      end else begin
        repeat ($urandom_range(3, 15)) push_sample(any_sample(), any_sample());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: threshold edges, same-tick delay, ordinary and saturated phase
    apply_settings(8'd128, GAIN_W'(1024), 1'b1);
    push_sample(8'd0, 8'd255);
    push_sample(8'd127, 8'd0);
    push_sample(8'd128, 8'd128);
    push_sample(8'd0, 8'd255);
    push_sample(8'd127, 8'd0);
    push_sample(8'd255, 8'd128);
    push_sample(8'd200, 8'd0);
    push_sample(8'd200, 8'd0);
    push_sample(8'd10, 8'd0);
    push_sample(8'd128, 8'd127);
    push_sample(8'd0, 8'd0);
    push_sample(8'd255, 8'd255);
    push_sample(8'd128, 8'd0);
    push_sample(8'd0, 8'd0);
    push_sample(8'd128, 8'd0);
    repeat (5) push_sample(8'd0, 8'd0);
    push_sample(8'd0, 8'd128);

    // random measurements under several settings
    run_phase(1, 0, 1'b1, 200, 1'b1);
    run_phase(255, 2047, 1'b1, 200, 1'b1);
    run_phase($urandom_range(2, 254), $urandom_range(0, 2047), 1'b1, 220, 1'b0);
    run_phase(128, GAIN_RESET, 1'b1, 220, 1'b1);
    run_phase($urandom_range(2, 254), $urandom_range(0, 2047), 1'b1, 220, 1'b1);
    run_phase($urandom_range(1, 255), 2047, 1'b1, 200, 1'b1);
    // single-shot mode: one result, then everything after is ignored
    run_phase($urandom_range(1, 255), $urandom_range(0, 2047), 1'b0, 60, 1'b0);
    settle();

    $display("%0d sample words in, %0d phase words checked, %0d mismatches",
             words_in, phase_words, errors);
    $display("%0d measurement sequences over %0d register settings, ending halted",
             gen_meas, settings_used);
    if (errors == 0 && phase_expect_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (phase_expect_q.size() != 0)
        $display("%0d phase words never arrived", phase_expect_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/tcpm_pkg.sv
rtl/core/tcpm_front.sv
rtl/core/tcpm_queue.sv
rtl/core/tcpm_back.sv
rtl/core/two_channel_phase_meter.sv
rtl/core/tcpm_checker.sv
dv/tb_two_channel_phase_meter.sv
